>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/dsps_pkg.sv
// ----------------------------------------------------------------------------
// dsps_pkg
// Shared types and codes of the drum step pattern store.
// ----------------------------------------------------------------------------
package dsps_pkg;

  // Operation codes carried in the kind field.
  localparam logic [2:0] KIND_SET    = 3'd0;
  localparam logic [2:0] KIND_GET    = 3'd1;
  localparam logic [2:0] KIND_CLICK  = 3'd2;
  localparam logic [2:0] KIND_ACCENT = 3'd3;
  localparam logic [2:0] KIND_ROTATE = 3'd4;
  localparam logic [2:0] KIND_RANDOM = 3'd5;

  // Hit codes.
  localparam logic [1:0] HIT_OFF  = 2'd0;
  localparam logic [1:0] HIT_LOW  = 2'd1;
  localparam logic [1:0] HIT_HIGH = 2'd2;
  localparam logic [1:0] HIT_FLAM = 2'd3;

  // Random fill generator and its thresholds.
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [3:0]  RAND_CLASSIC_LOW = 4'd11;
  localparam logic [3:0]  RAND_LOW         = 4'd8;
  localparam logic [3:0]  RAND_HIGH        = 4'd12;
  localparam logic [3:0]  RAND_FLAM        = 4'd15;

  // Register index of the class select.
  localparam logic CFG_IDX_SIMPLE_CLASS = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  step;
    logic [3:0]  track;
    logic [1:0]  hit_value;
    logic        accent_value;
    logic        flam_click;
    logic        direction;
    logic [31:0] seed;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [1:0] hit_result;
  } out_result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch the accepted item
    logic rd_wrap;   // read the row that wraps around on a rotate
    logic rd_first;  // read the first row of the sweep
    logic rd_next;   // read the following row
    logic cap_wrap;  // hold the lane of the wrap row
    logic wr_row;    // write back the row whose data arrives
    logic acc_wr;    // write the accent bit
    logic finish;    // latch the result
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic ok;        // item in range and allowed
    logic long_op;   // item walks rows of the store
    logic is_rotate;
    logic last_row;  // arriving row is the last of the sweep
  } dp_status_t;

endpackage

>>> sv/dsps_ram.sv
// ----------------------------------------------------------------------------
// dsps_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/dsps_ctrl.sv
// ----------------------------------------------------------------------------
// dsps_ctrl
// Sequencer: checks the item, then walks the pattern rows one per cycle.
// ----------------------------------------------------------------------------
module dsps_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  dsps_pkg::dp_status_t   status,
  output dsps_pkg::ctrl_cmd_t    cmd,
  output logic                   busy,
  output logic                   out_strobe
);

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_WRAP, ST_SWEEP} state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    busy_nxt   = busy_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
          busy_nxt  = 1'b1;
        end
      end
      ST_CHECK: begin
        if (!status.ok || !status.long_op) begin
          // rejected items and accent writes finish here
          cmd.acc_wr = status.ok;
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
          busy_nxt   = 1'b0;
          strobe_nxt = 1'b1;
        end else if (status.is_rotate) begin
          cmd.rd_wrap = 1'b1;
          state_nxt   = ST_WRAP;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = ST_SWEEP;
        end
      end
      ST_WRAP: begin
        cmd.cap_wrap = 1'b1;
        cmd.rd_first = 1'b1;
        state_nxt    = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.wr_row = 1'b1;
        if (status.last_row) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
          busy_nxt   = 1'b0;
          strobe_nxt = 1'b1;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        busy_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      busy_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      busy_r   <= busy_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = strobe_r;

endmodule

>>> sv/dsps_dpath.sv
// ----------------------------------------------------------------------------
// dsps_dpath
// Row store, lane edit, rotate carry, random generator and result register.
// ----------------------------------------------------------------------------
module dsps_dpath #(
  parameter int STEPS          = 16,
  parameter int TRACKS         = 16,
  parameter int CLASSIC_TRACKS = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   simple_class,
  input  dsps_pkg::in_item_t     in_item,
  input  dsps_pkg::ctrl_cmd_t    cmd,
  output dsps_pkg::dp_status_t   status,
  output dsps_pkg::out_result_t  out_result
);

  localparam int AW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int RW = 3 * TRACKS;
  localparam logic [AW-1:0] LAST = AW'(STEPS - 1);

  dsps_pkg::in_item_t    item_r;
  dsps_pkg::out_result_t result_r;
  logic [31:0]       lcg_r;
  logic [1:0]        carry_r;
  logic [AW-1:0]     rd_addr_r;
  logic              rd_vld_r;
  logic [STEPS-1:0]  row_vld_r;
  logic [STEPS-1:0]  accent_r;

  logic              is_set, is_get, is_click, is_accent, is_rotate, is_random, is_row_op;
  logic              step_ok, track_ok, classic_ok, ok;
  logic [TW-1:0]     tidx;
  logic [TRACKS-1:0] bitmask;
  logic [RW-1:0]     ram_rdata, row, wdata;
  logic [TRACKS-1:0] row_on, row_high, row_flam, on_new, high_new, flam_new;
  logic [1:0]        old_hit, click_hit, rand_hit, new_hit;
  logic [3:0]        rnd;
  logic              descend, re, we;
  logic [AW-1:0]     wrap_addr, start_addr, end_addr, next_addr, raddr;

  // Item decode and range checks.
  assign is_set    = (item_r.kind == dsps_pkg::KIND_SET);
  assign is_get    = (item_r.kind == dsps_pkg::KIND_GET);
  assign is_click  = (item_r.kind == dsps_pkg::KIND_CLICK);
  assign is_accent = (item_r.kind == dsps_pkg::KIND_ACCENT);
  assign is_rotate = (item_r.kind == dsps_pkg::KIND_ROTATE);
  assign is_random = (item_r.kind == dsps_pkg::KIND_RANDOM);
  assign is_row_op = is_set | is_get | is_click;

  assign step_ok    = ({3'b000, item_r.step} < 7'(STEPS));
  assign track_ok   = ({1'b0, item_r.track} < 5'(TRACKS));
  assign classic_ok = ({1'b0, item_r.track} < 5'(CLASSIC_TRACKS));

  always_comb begin
    ok = 1'b0;
    if (is_set) begin
      ok = step_ok & track_ok & ~(simple_class & item_r.hit_value[1]);
    end else if (is_get || is_click) begin
      ok = step_ok & track_ok;
    end else if (is_accent) begin
      ok = step_ok;
    end else if (is_rotate || is_random) begin
      ok = classic_ok;
    end
  end

  // Lane of the arriving row; rows never written read as zero.
  assign tidx     = TW'(item_r.track);
  assign bitmask  = TRACKS'(1) << tidx;
  assign row      = rd_vld_r ? ram_rdata : '0;
  assign row_on   = row[TRACKS-1:0];
  assign row_high = row[2*TRACKS-1:TRACKS];
  assign row_flam = row[RW-1:2*TRACKS];

  always_comb begin
    if (!row_on[tidx]) begin
      old_hit = dsps_pkg::HIT_OFF;
    end else if (row_high[tidx]) begin
      old_hit = dsps_pkg::HIT_HIGH;
    end else if (row_flam[tidx]) begin
      old_hit = dsps_pkg::HIT_FLAM;
    end else begin
      old_hit = dsps_pkg::HIT_LOW;
    end
  end

  always_comb begin
    if (simple_class) begin
      click_hit = (old_hit == dsps_pkg::HIT_OFF) ? dsps_pkg::HIT_LOW : dsps_pkg::HIT_OFF;
    end else if (item_r.flam_click) begin
      click_hit = (old_hit == dsps_pkg::HIT_OFF) ? dsps_pkg::HIT_FLAM : dsps_pkg::HIT_OFF;
    end else if (old_hit == dsps_pkg::HIT_OFF) begin
      click_hit = dsps_pkg::HIT_LOW;
    end else if (old_hit == dsps_pkg::HIT_LOW) begin
      click_hit = dsps_pkg::HIT_HIGH;
    end else begin
      click_hit = dsps_pkg::HIT_OFF;
    end
  end

  assign rnd = lcg_r[19:16];

  always_comb begin
    if (simple_class) begin
      rand_hit = (rnd < dsps_pkg::RAND_CLASSIC_LOW) ? dsps_pkg::HIT_OFF : dsps_pkg::HIT_LOW;
    end else if (rnd < dsps_pkg::RAND_LOW) begin
      rand_hit = dsps_pkg::HIT_OFF;
    end else if (rnd < dsps_pkg::RAND_HIGH) begin
      rand_hit = dsps_pkg::HIT_LOW;
    end else if (rnd < dsps_pkg::RAND_FLAM) begin
      rand_hit = dsps_pkg::HIT_HIGH;
    end else begin
      rand_hit = dsps_pkg::HIT_FLAM;
    end
  end

  always_comb begin
    case (item_r.kind)
      dsps_pkg::KIND_SET:    new_hit = item_r.hit_value;
      dsps_pkg::KIND_CLICK:  new_hit = click_hit;
      dsps_pkg::KIND_ROTATE: new_hit = carry_r;
      dsps_pkg::KIND_RANDOM: new_hit = rand_hit;
      default:               new_hit = dsps_pkg::HIT_OFF;
    endcase
  end

  assign on_new   = (row_on & ~bitmask)
                  | ((new_hit != dsps_pkg::HIT_OFF) ? bitmask : '0);
  assign high_new = (row_high & ~bitmask)
                  | ((new_hit == dsps_pkg::HIT_HIGH) ? bitmask : '0);
  assign flam_new = (row_flam & ~bitmask)
                  | ((new_hit == dsps_pkg::HIT_FLAM) ? bitmask : '0);
  assign wdata    = {flam_new, high_new, on_new};

  // Row addressing: rotate toward earlier steps sweeps downward.
  assign descend    = is_rotate & ~item_r.direction;
  assign wrap_addr  = item_r.direction ? LAST : '0;
  assign start_addr = is_row_op ? AW'(item_r.step) : (descend ? LAST : '0);
  assign end_addr   = descend ? '0 : LAST;
  assign next_addr  = descend ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));

  always_comb begin
    if (cmd.rd_wrap) begin
      raddr = wrap_addr;
    end else if (cmd.rd_first) begin
      raddr = start_addr;
    end else begin
      raddr = next_addr;
    end
  end

  assign re = cmd.rd_wrap | cmd.rd_first | cmd.rd_next;
  assign we = cmd.wr_row & ~is_get;

  dsps_ram #(
    .WIDTH (RW),
    .DEPTH (STEPS)
  ) u_rows (
    .clk   (clk),
    .we    (we),
    .waddr (rd_addr_r),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      lcg_r  <= in_item.seed;
    end else if (re) begin
      // advance once per row read so the write sees this row's value
      lcg_r <= lcg_r * dsps_pkg::LCG_MUL + dsps_pkg::LCG_ADD;
    end
    if (re) begin
      rd_addr_r <= raddr;
      rd_vld_r  <= row_vld_r[raddr];
    end
    if (cmd.cap_wrap || cmd.wr_row) begin
      carry_r <= old_hit;
    end
    if (cmd.finish) begin
      result_r.status <= ~ok;
      if (ok && is_get) begin
        result_r.hit_result <= old_hit;
      end else if (ok && is_click) begin
        result_r.hit_result <= click_hit;
      end else begin
        result_r.hit_result <= dsps_pkg::HIT_OFF;
      end
    end
  end

  // Row valid bits and accent bits clear at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      accent_r  <= '0;
    end else begin
      if (we) begin
        row_vld_r[rd_addr_r] <= 1'b1;
      end
      if (cmd.acc_wr && is_accent) begin
        accent_r[AW'(item_r.step)] <= item_r.accent_value;
      end
    end
  end

  assign status.ok        = ok;
  assign status.long_op   = is_row_op | is_rotate | is_random;
  assign status.is_rotate = is_rotate;
  assign status.last_row  = is_row_op | (rd_addr_r == end_addr);
  assign out_result       = result_r;

endmodule

>>> sv/drum_step_pattern_store_core.sv
// ----------------------------------------------------------------------------
// drum_step_pattern_store_core
// Drum pattern store: per-step hit lanes, click cycling, rotate and random fill.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Every item gives
// exactly one result, shown for a single cycle with out_strobe high; the
// receiver cannot hold it off, so capture it in that cycle. Busy drops in the
// same cycle the result shows, and a new item may be started right then.
// An accent write or a rejected item ends after the check; set and click read
// and write back one row and get reads one; a random fill sweeps all STEPS
// rows, and a rotate reads the wrap row first, then sweeps all rows. The
// pattern lives in a row RAM of STEPS words, one word per step holding the
// on, high and flam masks of all tracks; a row is read and written back once
// per cycle, which sets the sweep length. Rows clear at reset through per-row
// valid bits, so there is no clearing pass and the block is ready in the first
// cycle after reset. The user must write the class select (register 0) through
// the APB port only while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module drum_step_pattern_store_core #(
  parameter int STEPS          = 16,
  parameter int TRACKS         = 16,
  parameter int CLASSIC_TRACKS = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item channel
  input  logic                  start,
  output logic                  busy,
  input  dsps_pkg::in_item_t    in_item,
  // result channel
  output logic                  out_strobe,
  output dsps_pkg::out_result_t out_result,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  dsps_pkg::ctrl_cmd_t  cmd;
  dsps_pkg::dp_status_t status;
  logic                 simple_class_r;
  logic                 cfg_hit;

  // Register 0 sits at byte address 0; byte offset bits are ignored.
  assign cfg_hit = (paddr[2] == dsps_pkg::CFG_IDX_SIMPLE_CLASS);

  // Take the class select on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      simple_class_r <= 1'b0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      simple_class_r <= pwdata[0];
    end
  end

  assign prdata = cfg_hit ? {31'b0, simple_class_r} : '0;
  assign pready = 1'b1;

  // Sequencer: decides per cycle which row to read and whether to write back.
  dsps_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // Datapath: row RAM, lane edit, rotate carry, random generator, result hold.
  dsps_dpath #(
    .STEPS          (STEPS),
    .TRACKS         (TRACKS),
    .CLASSIC_TRACKS (CLASSIC_TRACKS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .simple_class (simple_class_r),
    .in_item      (in_item),
    .cmd          (cmd),
    .status       (status),
    .out_result   (out_result)
  );

endmodule

>>> sv/dsps_checker.sv
// ----------------------------------------------------------------------------
// dsps_checker
// Port-level checks of the item and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dsps_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_strobe,
  input dsps_pkg::out_result_t out_result
);

  // An accepted transfer raises busy in the following cycle.
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

  // No result can show in the cycle right after an accept.
  `ASSERT_NEXT(a_no_early_result, start && !busy, !out_strobe, "result too early")

  // Busy drops exactly when the result shows.
  `ASSERT_IMPLIES(a_fall_strobe, $fell(busy) && $past(rst_n), out_strobe,
                  "busy dropped without a result")

  // A rejected item carries no hit.
  `ASSERT_IMPLIES(a_reject_hit, out_strobe && out_result.status,
                  out_result.hit_result == dsps_pkg::HIT_OFF, "rejected item carries a hit")

endmodule

bind drum_step_pattern_store_core dsps_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks drum_step_pattern_store_core against a cycle-free pattern model kept
// here: every accepted command updates the model, and every result transfer
// is compared with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_STEPS       = 16;
  localparam int NUM_TRACKS      = 16;
  localparam int NUM_CLASSIC     = 11;
  localparam int MAX_GAP         = 60;   // longest sender idle stretch
  localparam int TAIL_CYCLES     = 30;   // longer than a rotate sweep
  localparam int ITEMS_PER_PHASE = 270;

  // Kind codes the block must reject.
  localparam logic [2:0] KIND_BAD6 = 3'd6;
  localparam logic [2:0] KIND_BAD7 = 3'd7;

  // Register map: index i at byte address 4*i.
  localparam logic [2:0] ADDR_SIMPLE_CLASS = 3'(4 * dsps_pkg::CFG_IDX_SIMPLE_CLASS);
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  dsps_pkg::in_item_t    in_item;
  logic                  out_strobe;
  dsps_pkg::out_result_t out_result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // Pattern model state and the class select as the block should hold them.
  logic [NUM_TRACKS-1:0] on_mask     [NUM_STEPS];
  logic [NUM_TRACKS-1:0] high_mask   [NUM_STEPS];
  logic [NUM_TRACKS-1:0] flam_mask   [NUM_STEPS];
  logic                  accent_mask [NUM_STEPS];
  logic                  class_808;

  dsps_pkg::out_result_t pending_results[$];
  dsps_pkg::out_result_t want_result;
  int                    err_count;
  int                    sender_idle_pct;

  drum_step_pattern_store_core #(
    .STEPS         (NUM_STEPS),
    .TRACKS        (NUM_TRACKS),
    .CLASSIC_TRACKS(NUM_CLASSIC)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Pattern model
  // --------------------------------------------------------------------------
  function automatic logic [1:0] lane_hit(int st, int tr);
    if (!on_mask[st][tr]) return dsps_pkg::HIT_OFF;
    if (high_mask[st][tr]) return dsps_pkg::HIT_HIGH;
    if (flam_mask[st][tr]) return dsps_pkg::HIT_FLAM;
    return dsps_pkg::HIT_LOW;
  endfunction

  function automatic void put_lane(int st, int tr, logic [1:0] hit);
    on_mask[st][tr]   = (hit != dsps_pkg::HIT_OFF);
    high_mask[st][tr] = (hit == dsps_pkg::HIT_HIGH);
    flam_mask[st][tr] = (hit == dsps_pkg::HIT_FLAM);
  endfunction

  // Apply one command to the model and return the result it should give.
  // Step and track fields cannot exceed the 16-entry store, so only the
  // classic-track limit of rotate and random fill can reject on range.
  function automatic dsps_pkg::out_result_t predict_pattern_op(dsps_pkg::in_item_t it);
    dsps_pkg::out_result_t res;
    logic [1:0]  cur;
    logic [1:0]  nxt;
    logic [1:0]  lane [NUM_STEPS];
    logic [31:0] lcg;
    logic [3:0]  r;
    res.status     = 1'b1;
    res.hit_result = dsps_pkg::HIT_OFF;
    case (it.kind)
      dsps_pkg::KIND_SET: begin
        if (!(class_808 && (it.hit_value == dsps_pkg::HIT_HIGH ||
                            it.hit_value == dsps_pkg::HIT_FLAM))) begin
          put_lane(it.step, it.track, it.hit_value);
          res.status = 1'b0;
        end
      end
      dsps_pkg::KIND_GET: begin
        res.hit_result = lane_hit(it.step, it.track);
        res.status     = 1'b0;
      end
      dsps_pkg::KIND_CLICK: begin
        cur = lane_hit(it.step, it.track);
        if (class_808)
          nxt = (cur == dsps_pkg::HIT_OFF) ? dsps_pkg::HIT_LOW : dsps_pkg::HIT_OFF;
        else if (it.flam_click)
          nxt = (cur == dsps_pkg::HIT_OFF) ? dsps_pkg::HIT_FLAM : dsps_pkg::HIT_OFF;
        else if (cur == dsps_pkg::HIT_OFF)
          nxt = dsps_pkg::HIT_LOW;
        else if (cur == dsps_pkg::HIT_LOW)
          nxt = dsps_pkg::HIT_HIGH;
        else
          nxt = dsps_pkg::HIT_OFF;
        put_lane(it.step, it.track, nxt);
        res.hit_result = nxt;
        res.status     = 1'b0;
      end
      dsps_pkg::KIND_ACCENT: begin
        accent_mask[it.step] = it.accent_value;
        res.status           = 1'b0;
      end
      dsps_pkg::KIND_ROTATE: begin
        if (it.track < NUM_CLASSIC) begin
          for (int i = 0; i < NUM_STEPS; i++) lane[i] = lane_hit(i, it.track);
          for (int i = 0; i < NUM_STEPS; i++)
            put_lane(i, it.track, it.direction ? lane[(i + NUM_STEPS - 1) % NUM_STEPS]
                                               : lane[(i + 1) % NUM_STEPS]);
          res.status = 1'b0;
        end
      end
      dsps_pkg::KIND_RANDOM: begin
        if (it.track < NUM_CLASSIC) begin
          lcg = it.seed;
          for (int i = 0; i < NUM_STEPS; i++) begin
            lcg = lcg * dsps_pkg::LCG_MUL + dsps_pkg::LCG_ADD;
            r   = lcg[19:16];
            if (class_808)
              nxt = (r < dsps_pkg::RAND_CLASSIC_LOW) ? dsps_pkg::HIT_OFF : dsps_pkg::HIT_LOW;
            else if (r < dsps_pkg::RAND_LOW)
              nxt = dsps_pkg::HIT_OFF;
            else if (r < dsps_pkg::RAND_HIGH)
              nxt = dsps_pkg::HIT_LOW;
            else if (r < dsps_pkg::RAND_FLAM)
              nxt = dsps_pkg::HIT_HIGH;
            else
              nxt = dsps_pkg::HIT_FLAM;
            put_lane(i, it.track, nxt);
          end
          res.status = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic dsps_pkg::in_item_t make_op(logic [2:0] kind, logic [3:0] step,
                                                 logic [3:0] track, logic [1:0] hit,
                                                 logic accent, logic flam, logic dir,
                                                 logic [31:0] seed);
    dsps_pkg::in_item_t it;
    it.kind         = kind;
    it.step         = step;
    it.track        = track;
    it.hit_value    = hit;
    it.accent_value = accent;
    it.flam_click   = flam;
    it.direction    = dir;
    it.seed         = seed;
    return it;
  endfunction

  // Random command: every field random, kind weighted toward edits and reads
  // so the pattern fills up and reads see all hit codes.
  function automatic dsps_pkg::in_item_t rand_pattern_op();
    dsps_pkg::in_item_t it;
    int                 pick;
    it.step         = 4'($urandom_range(15));
    it.track        = 4'($urandom_range(15));
    it.hit_value    = 2'($urandom_range(3));
    it.accent_value = 1'($urandom_range(1));
    it.flam_click   = 1'($urandom_range(1));
    it.direction    = 1'($urandom_range(1));
    it.seed         = $urandom();
    pick            = $urandom_range(99);
    if (pick < 24)      it.kind = dsps_pkg::KIND_SET;
    else if (pick < 48) it.kind = dsps_pkg::KIND_GET;
    else if (pick < 68) it.kind = dsps_pkg::KIND_CLICK;
    else if (pick < 76) it.kind = dsps_pkg::KIND_ACCENT;
    else if (pick < 85) it.kind = dsps_pkg::KIND_ROTATE;
    else if (pick < 94) it.kind = dsps_pkg::KIND_RANDOM;
    else                it.kind = 3'($urandom_range(7));
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one command: idle a random stretch, hold start until the transfer,
  // then record the predicted result. Start stays high on return so the next
  // command can follow back to back.
  task automatic send_pattern_op(input dsps_pkg::in_item_t it);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_pattern_op(it));
  endtask

  // Drop start and hold until every predicted result has arrived.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Only register 0 exists; writes elsewhere leave the class alone.
    if (addr == ADDR_SIMPLE_CLASS) class_808 = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SIMPLE_CLASS;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, class_808}) begin
      $error("simple_class: expected %0d, actual %0d", class_808, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change the class select with the block idle, then read it back.
  task automatic set_class(input logic cls);
    drain_results();
    cfg_write(ADDR_SIMPLE_CLASS, {31'b0, cls});
    cfg_read_check();
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare each result transfer with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d, hit_result %0d",
               out_result.status, out_result.hit_result);
        err_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (out_result.status !== want_result.status) begin
          $error("status: expected %0d, actual %0d", want_result.status, out_result.status);
          err_count++;
        end
        if (out_result.hit_result !== want_result.hit_result) begin
          $error("hit_result: expected %0d, actual %0d",
                 want_result.hit_result, out_result.hit_result);
          err_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Read corner cells straight after reset: the store must come up cleared.
  task automatic test_reset_state();
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd0, 4'd0, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd15, 4'd15, dsps_pkg::HIT_FLAM,
                            1'b1, 1'b1, 1'b1, '1));
  endtask

  // Every operation with extreme fields, the full click cycles, wrap-around
  // of a flam hit, classic-track rejects and the unused kinds.
  task automatic test_basic_ops();
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd0, 4'd0, dsps_pkg::HIT_LOW,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd15, 4'd15, dsps_pkg::HIT_FLAM,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd15, 4'd15, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd7, 4'd3, dsps_pkg::HIT_HIGH,
                            1'b0, 1'b0, 1'b0, 32'd0));
    // Off, low, high, off, low.
    repeat (4)
      send_pattern_op(make_op(dsps_pkg::KIND_CLICK, 4'd4, 4'd2, dsps_pkg::HIT_OFF,
                              1'b0, 1'b0, 1'b0, 32'd0));
    // Flam mode: low, off, flam.
    repeat (2)
      send_pattern_op(make_op(dsps_pkg::KIND_CLICK, 4'd4, 4'd2, dsps_pkg::HIT_OFF,
                              1'b0, 1'b1, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_ACCENT, 4'd0, 4'd0, dsps_pkg::HIT_OFF,
                            1'b1, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_ACCENT, 4'd15, 4'd15, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    // Rotate track 0 earlier: the low hit at step 0 wraps to step 15.
    send_pattern_op(make_op(dsps_pkg::KIND_ROTATE, 4'd0, 4'd0, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd15, 4'd0, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    // Rotate track 1 later: a flam at step 15 must arrive whole at step 0.
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd15, 4'd1, dsps_pkg::HIT_FLAM,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_ROTATE, 4'd0, 4'd1, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b1, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd0, 4'd1, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    // Beyond the classic tracks rotate and fill are refused.
    send_pattern_op(make_op(dsps_pkg::KIND_ROTATE, 4'd0, 4'd15, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b1, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_RANDOM, 4'd0, 4'd11, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_RANDOM, 4'd0, 4'd10, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, '1));
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd9, 4'd10, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(KIND_BAD6, 4'd3, 4'd3, dsps_pkg::HIT_LOW,
                            1'b1, 1'b1, 1'b1, '1));
    send_pattern_op(make_op(KIND_BAD7, 4'd15, 4'd0, dsps_pkg::HIT_HIGH,
                            1'b0, 1'b0, 1'b0, 32'd0));
  endtask

  // 808 class: high and flam writes refused, clicks toggle off and low,
  // random fill uses the classic threshold; a write to an unmapped address
  // must not touch the class select.
  task automatic test_class_808();
    set_class(1'b1);
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd3, 4'd4, dsps_pkg::HIT_HIGH,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd3, 4'd4, dsps_pkg::HIT_FLAM,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_CLICK, 4'd7, 4'd3, dsps_pkg::HIT_OFF,
                            1'b0, 1'b1, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_CLICK, 4'd7, 4'd3, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_RANDOM, 4'd0, 4'd0, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    drain_results();
    cfg_write(ADDR_UNMAPPED, 32'd0);
    cfg_read_check();
    send_pattern_op(make_op(dsps_pkg::KIND_SET, 4'd3, 4'd4, dsps_pkg::HIT_LOW,
                            1'b0, 1'b0, 1'b0, 32'd0));
    send_pattern_op(make_op(dsps_pkg::KIND_GET, 4'd3, 4'd4, dsps_pkg::HIT_OFF,
                            1'b0, 1'b0, 1'b0, 32'd0));
    set_class(1'b0);
  endtask

  // Random traffic in phases of class select and sender idling. Mid-way
  // through the first phase, and now and then in any phase, hold the sender
  // until the block has answered everything.
  task automatic test_random_traffic();
    int   idle_by_phase [5];
    logic class_by_phase [5];
    idle_by_phase  = '{0, 86, 0, 34, 34};
    class_by_phase = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    for (int ph = 0; ph < 5; ph++) begin
      set_class(class_by_phase[ph]);
      sender_idle_pct = idle_by_phase[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ((ph == 0 && n == ITEMS_PER_PHASE / 2) || $urandom_range(199) == 0)
          drain_results();
        send_pattern_op(rand_pattern_op());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    err_count       = 0;
    sender_idle_pct = 0;
    class_808       = 1'b0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      on_mask[i]     = '0;
      high_mask[i]   = '0;
      flam_mask[i]   = '0;
      accent_mask[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_basic_ops();
    test_class_808();
    test_random_traffic();

    // Wait out the last results, then give stray strobes a chance to show.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> drum_step_pattern_store_core.f
+incdir+sv
sv/dsps_pkg.sv
sv/dsps_ram.sv
sv/dsps_ctrl.sv
sv/dsps_dpath.sv
sv/drum_step_pattern_store_core.sv
sv/dsps_checker.sv
bench/testbench.sv
